// ----- hw/rtl/char_display_diff_refresh_core_defines.svh -----
// Assertion macros for the character display refresh core.
// Each macro takes a label, the clock, the reset and two expressions.
`ifndef CHAR_DISPLAY_DIFF_REFRESH_CORE_DEFINES_SVH
`define CHAR_DISPLAY_DIFF_REFRESH_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define CDR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication.
`define CDR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define CDR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CDR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hw/rtl/cdr_pkg.sv -----
package cdr_pkg;

   localparam int POS_W  = 7;
   localparam int CHAR_W = 8;

   localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
   localparam logic [CHAR_W-1:0] SET_ADDR_CMD   = 8'h80;
   localparam logic [CHAR_W-1:0] CURSOR_UNKNOWN = 8'hFF;

   localparam logic CMD_STORE   = 1'b0;
   localparam logic CMD_SERVICE = 1'b1;

   localparam logic RS_INSTR = 1'b0;
   localparam logic RS_DATA  = 1'b1;

   typedef struct packed {
      logic              command;
      logic [POS_W-1:0]  position;
      logic [CHAR_W-1:0] character;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] panel_byte;
      logic              register_select;
      logic              last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SPLIT,
      ST_SCAN,
      ST_ADDR,
      ST_DATA
   } state_type;

   // Interleaved row base addresses of the panel.
   function automatic logic [CHAR_W-1:0] row_start_addr(input logic [1:0] row);
      logic [CHAR_W-1:0] base;
      unique case (row)
         2'd0: base = 8'h00;
         2'd1: base = 8'h40;
         2'd2: base = 8'h14;
         2'd3: base = 8'h54;
         default: base = 8'h00;
      endcase
      return base;
   endfunction

endpackage

// ----- hw/rtl/char_display_diff_refresh_core.sv -----
// Channel   Ports                          Direction  Moves
// request   req_valid/req_ready/req_data   in         store or service transaction
// response  rsp_valid/rsp_ready/rsp_data   out        panel byte transaction
// control   csr_wr_en/csr_wr_data          in         display enable write
//
// Store transaction: written to the wanted memory. Service transaction (display
// enabled): split the scan pointer into row and column by repeated subtraction,
// then stream both screen memories through the comparator (one cell a cycle,
// registered reads) to the first mismatch, then emit 1 or 2 bytes. A disabled
// service transaction is dropped. After reset a clearing pass writes spaces to
// both memories; req_ready stays low throughout. Results wait in the output
// register; a new transaction is taken meanwhile; emission stalls until it frees.
`include "char_display_diff_refresh_core_defines.svh"

module char_display_diff_refresh_core
   import cdr_pkg::*;
#(
   parameter int COLUMNS = 20,
   parameter int CELLS   = 80
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data
);

   localparam int IDX_W = $clog2(CELLS);
   localparam int COL_W = $clog2(COLUMNS);
   localparam int CNT_W = $clog2(CELLS + 1);

   // Screen memories: wanted characters and shadow of the panel.
   logic [CHAR_W-1:0] wanted_ff [CELLS];
   logic [CHAR_W-1:0] shadow_ff [CELLS];
   logic [CHAR_W-1:0] wanted_rd_ff;
   logic [CHAR_W-1:0] shadow_rd_ff;

   logic              wanted_we;
   logic [IDX_W-1:0]  wanted_wa;
   logic [CHAR_W-1:0] wanted_wd;
   logic              shadow_we;
   logic [IDX_W-1:0]  shadow_wa;
   logic [CHAR_W-1:0] shadow_wd;

   // Control state.
   state_type         state_ff, state_in;
   logic              enable_ff, enable_in;
   logic [IDX_W-1:0]  scan_ptr_ff, scan_ptr_in;
   logic [CHAR_W-1:0] cursor_ff, cursor_in;
   logic [IDX_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [CNT_W-1:0]  iss_cnt_ff, iss_cnt_in;
   logic [CNT_W-1:0]  cmp_cnt_ff, cmp_cnt_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Scan walker and split datapath.
   logic [IDX_W-1:0]  rem_ff, rem_in;
   logic [1:0]        row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [1:0]        rd_row_ff;
   logic [COL_W-1:0]  rd_col_ff;
   logic [IDX_W-1:0]  rd_idx_ff;

   // Captured cell to send.
   logic [IDX_W-1:0]  fnd_idx_ff, fnd_idx_in;
   logic [CHAR_W-1:0] fnd_char_ff, fnd_char_in;
   logic [CHAR_W-1:0] fnd_addr_ff, fnd_addr_in;
   logic              fnd_lastcol_ff, fnd_lastcol_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              rsp_free;
   logic              issue;
   logic              col_last;
   logic              idx_last;
   logic              mismatch;
   logic [CHAR_W-1:0] cell_addr;
   logic [IDX_W-1:0]  next_ptr;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // Walker position and the cell under compare.
   assign issue     = (iss_cnt_ff != CNT_W'(CELLS));
   assign col_last  = (col_ff == COL_W'(COLUMNS - 1));
   assign idx_last  = (idx_ff == IDX_W'(CELLS - 1));
   assign mismatch  = rd_vld_ff && (wanted_rd_ff != shadow_rd_ff);
   assign cell_addr = row_start_addr(rd_row_ff) + CHAR_W'(rd_col_ff);
   assign next_ptr  = (fnd_idx_ff == IDX_W'(CELLS - 1)) ? '0 : fnd_idx_ff + 1'b1;

   always_comb begin
      state_in       = state_ff;
      enable_in      = csr_wr_en ? csr_wr_data : enable_ff;
      scan_ptr_in    = scan_ptr_ff;
      cursor_in      = cursor_ff;
      clr_cnt_in     = clr_cnt_ff;
      iss_cnt_in     = iss_cnt_ff;
      cmp_cnt_in     = cmp_cnt_ff;
      rd_vld_in      = 1'b0;
      rem_in         = rem_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      idx_in         = idx_ff;
      fnd_idx_in     = fnd_idx_ff;
      fnd_char_in    = fnd_char_ff;
      fnd_addr_in    = fnd_addr_ff;
      fnd_lastcol_in = fnd_lastcol_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      wanted_we      = 1'b0;
      wanted_wa      = IDX_W'(req_data.position);
      wanted_wd      = req_data.character;
      shadow_we      = 1'b0;
      shadow_wa      = fnd_idx_ff;
      shadow_wd      = fnd_char_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            wanted_we = 1'b1;
            wanted_wa = clr_cnt_ff;
            wanted_wd = BLANK_CHAR;
            shadow_we = 1'b1;
            shadow_wa = clr_cnt_ff;
            shadow_wd = BLANK_CHAR;
            if (clr_cnt_ff == IDX_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.command == CMD_STORE) begin
                  // Drop stores beyond the last cell.
                  wanted_we = (8'(req_data.position) < 8'(CELLS));
               end else if (enable_ff) begin
                  rem_in   = scan_ptr_ff;
                  row_in   = 2'd0;
                  state_in = ST_SPLIT;
               end
            end
         end
         ST_SPLIT: begin
            // Repeated subtraction of the row length.
            if (rem_ff >= IDX_W'(COLUMNS)) begin
               rem_in = rem_ff - IDX_W'(COLUMNS);
               row_in = row_ff + 1'b1;
            end else begin
               col_in     = COL_W'(rem_ff);
               idx_in     = scan_ptr_ff;
               iss_cnt_in = '0;
               cmp_cnt_in = '0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (mismatch) begin
               fnd_idx_in     = rd_idx_ff;
               fnd_char_in    = wanted_rd_ff;
               fnd_addr_in    = cell_addr;
               fnd_lastcol_in = (rd_col_ff == COL_W'(COLUMNS - 1));
               state_in       = (cursor_ff != cell_addr) ? ST_ADDR : ST_DATA;
            end else if (rd_vld_ff && (cmp_cnt_ff == CNT_W'(CELLS - 1))) begin
               // Every cell matches: nothing to send.
               state_in = ST_IDLE;
            end else begin
               if (rd_vld_ff) begin
                  cmp_cnt_in = cmp_cnt_ff + 1'b1;
               end
               if (issue) begin
                  rd_vld_in  = 1'b1;
                  iss_cnt_in = iss_cnt_ff + 1'b1;
                  if (idx_last) begin
                     idx_in = '0;
                     col_in = '0;
                     row_in = 2'd0;
                  end else if (col_last) begin
                     idx_in = idx_ff + 1'b1;
                     col_in = '0;
                     row_in = row_ff + 1'b1;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                     col_in = col_ff + 1'b1;
                  end
               end
            end
         end
         ST_ADDR: begin
            if (rsp_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.panel_byte      = SET_ADDR_CMD | fnd_addr_ff;
               rsp_data_in.register_select = RS_INSTR;
               rsp_data_in.last            = 1'b0;
               state_in                    = ST_DATA;
            end
         end
         ST_DATA: begin
            if (rsp_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.panel_byte      = fnd_char_ff;
               rsp_data_in.register_select = RS_DATA;
               rsp_data_in.last            = 1'b1;
               shadow_we                   = 1'b1;
               // Advance the cursor; lose it past the end of a row.
               cursor_in   = fnd_lastcol_ff ? CURSOR_UNKNOWN : fnd_addr_ff + 1'b1;
               scan_ptr_in = next_ptr;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         enable_ff    <= 1'b0;
         scan_ptr_ff  <= '0;
         cursor_ff    <= '0;
         clr_cnt_ff   <= '0;
         iss_cnt_ff   <= '0;
         cmp_cnt_ff   <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         scan_ptr_ff  <= scan_ptr_in;
         cursor_ff    <= cursor_in;
         clr_cnt_ff   <= clr_cnt_in;
         iss_cnt_ff   <= iss_cnt_in;
         cmp_cnt_ff   <= cmp_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers; hold the walker position alongside each read.
   always_ff @(posedge clock) begin
      rem_ff         <= rem_in;
      row_ff         <= row_in;
      col_ff         <= col_in;
      idx_ff         <= idx_in;
      rd_row_ff      <= row_ff;
      rd_col_ff      <= col_ff;
      rd_idx_ff      <= idx_ff;
      fnd_idx_ff     <= fnd_idx_in;
      fnd_char_ff    <= fnd_char_in;
      fnd_addr_ff    <= fnd_addr_in;
      fnd_lastcol_ff <= fnd_lastcol_in;
      rsp_data_ff    <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wanted_we) begin
         wanted_ff[wanted_wa] <= wanted_wd;
      end
      wanted_rd_ff <= wanted_ff[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (shadow_we) begin
         shadow_ff[shadow_wa] <= shadow_wd;
      end
      shadow_rd_ff <= shadow_ff[idx_ff];
   end

   `CDR_ASSERT_NEXT(a_data_follows_addr, clock, reset, rsp_valid && rsp_ready && (rsp_data.register_select == RS_INSTR), rsp_valid && (rsp_data.register_select == RS_DATA) && rsp_data.last)
   `CDR_ASSERT_IMPL(a_instr_is_set_addr, clock, reset, rsp_valid && (rsp_data.register_select == RS_INSTR), rsp_data.panel_byte[7] && !rsp_data.last)
   `CDR_ASSERT_IMPL(a_scan_ptr_in_range, clock, reset, 1'b1, 8'(scan_ptr_ff) < 8'(CELLS))
   `CDR_ASSERT_IMPL(a_compare_behind_issue, clock, reset, state_ff == ST_SCAN, cmp_cnt_ff <= iss_cnt_ff)

endmodule
